@@ rtl/fol_pkg.sv @@
`default_nettype none
package fol_pkg;

	localparam int KEY_W    = 32;
	localparam int COUNT_W  = 16;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 3;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [POS_W-1:0]    pos_t;

	// Operation codes carried in the func field.
	localparam func_t FN_APPEND = 2'd0;
	localparam func_t FN_LOCATE = 2'd1;
	localparam func_t FN_CLEAR  = 2'd2;

	// Result status codes.
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_MISSING = 2'd1;
	localparam status_t ST_FULL    = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_UPDATE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the incoming beat
		logic look;    // run the key search and register its outcome
		logic commit;  // update the table and load the result register
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/fol_dp.sv @@
`default_nettype none
module fol_dp #(
	parameter int ENTRIES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fol_pkg::cmd_t     cmd,
	input  wire fol_pkg::func_t    func,
	input  wire fol_pkg::key_t     key_value,
	output fol_pkg::status_t       status,
	output fol_pkg::pos_t          position
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// Table storage, front first.
	fol_pkg::key_t   key_store_q   [ENTRIES];
	fol_pkg::count_t count_store_q [ENTRIES];
	logic [CW-1:0]   entry_count_q;

	// Captured operation.
	fol_pkg::func_t  func_q;
	fol_pkg::key_t   key_q;

	// Search results registered for the update cycle.
	logic            hit_s1;
	logic [IW-1:0]   idx_s1;
	fol_pkg::count_t cnew_s1;

	// Result register.
	fol_pkg::status_t status_q;
	fol_pkg::pos_t    position_q;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] first_hit;
	logic [IW-1:0]      idx_d;
	fol_pkg::count_t    csel;
	fol_pkg::count_t    cnew_d;
	logic [ENTRIES-1:0] blocker;
	logic [IW-1:0]      dest;
	logic               full;
	fol_pkg::key_t      key_prev   [ENTRIES];
	fol_pkg::count_t    count_prev [ENTRIES];

	assign full = (entry_count_q == CW'(ENTRIES));

	// Parallel compare against every valid entry, keep the frontmost hit.
	always_comb begin
		for (int j = 0; j < ENTRIES; j++) begin
			match[j] = (CW'(j) < entry_count_q) && (key_store_q[j] == key_q);
		end
		first_hit = match & (~match + ENTRIES'(1));
		idx_d = '0;
		csel  = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			if (first_hit[j]) begin
				idx_d = idx_d | IW'(j);
			end
			csel = csel | ({fol_pkg::COUNT_W{first_hit[j]}} & count_store_q[j]);
		end
		cnew_d = (csel == '1) ? csel : csel + fol_pkg::count_t'(1);
	end

	// The entry moves ahead of the run of entries just in front of it whose
	// count does not exceed its new count; the nearest larger count stops it.
	always_comb begin
		for (int j = 0; j < ENTRIES; j++) begin
			blocker[j] = (IW'(j) < idx_s1) && (count_store_q[j] > cnew_s1);
		end
		dest = '0;
		for (int j = 0; j < ENTRIES - 1; j++) begin
			if (blocker[j]) begin
				dest = IW'(j + 1);
			end
		end
	end

	always_comb begin
		key_prev[0]   = key_store_q[0];
		count_prev[0] = count_store_q[0];
		for (int j = 1; j < ENTRIES; j++) begin
			key_prev[j]   = key_store_q[j-1];
			count_prev[j] = count_store_q[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			key_q  <= key_value;
		end
		if (cmd.look) begin
			hit_s1  <= |match;
			idx_s1  <= idx_d;
			cnew_s1 <= cnew_d;
		end
	end

	// Table update. The located key equals the search key, so the key written
	// at the destination comes straight from the captured beat.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (func_q == fol_pkg::FN_APPEND) begin
					if (!full && CW'(j) == entry_count_q) begin
						key_store_q[j]   <= key_q;
						count_store_q[j] <= '0;
					end
				end else if (func_q == fol_pkg::FN_LOCATE && hit_s1) begin
					if (IW'(j) == dest) begin
						key_store_q[j]   <= key_q;
						count_store_q[j] <= cnew_s1;
					end else if (IW'(j) > dest && IW'(j) <= idx_s1) begin
						key_store_q[j]   <= key_prev[j];
						count_store_q[j] <= count_prev[j];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cmd.commit) begin
			if (func_q == fol_pkg::FN_APPEND && !full) begin
				entry_count_q <= entry_count_q + CW'(1);
			end else if (func_q == fol_pkg::FN_CLEAR) begin
				entry_count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			unique case (func_q)
				fol_pkg::FN_APPEND: begin
					status_q   <= full ? fol_pkg::ST_FULL : fol_pkg::ST_OK;
					position_q <= '0;
				end
				fol_pkg::FN_LOCATE: begin
					status_q   <= hit_s1 ? fol_pkg::ST_OK : fol_pkg::ST_MISSING;
					position_q <= hit_s1 ? fol_pkg::pos_t'(dest) : fol_pkg::pos_t'(0);
				end
				default: begin
					status_q   <= fol_pkg::ST_OK;
					position_q <= '0;
				end
			endcase
		end
	end

	assign status   = status_q;
	assign position = position_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(ENTRIES))
		else $error("entry count exceeds table size");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && func_q == fol_pkg::FN_CLEAR |=> entry_count_q == '0)
		else $error("clear did not empty the table");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && func_q == fol_pkg::FN_APPEND && full |=> entry_count_q == CW'(ENTRIES))
		else $error("rejected append changed the entry count");

endmodule
`default_nettype wire

@@ rtl/fol_ctrl.sv @@
`default_nettype none
module fol_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output fol_pkg::cmd_t   cmd
);

	fol_pkg::state_t state_q;
	fol_pkg::state_t state_d;
	logic            out_valid_q;
	logic            slot_free;

	// The result register can take a new result if empty or being drained.
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fol_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.look   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			fol_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = fol_pkg::S_LOOK;
				end
			end
			fol_pkg::S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = fol_pkg::S_UPDATE;
			end
			fol_pkg::S_UPDATE: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					in_ready   = 1'b1;
					state_d    = in_valid ? fol_pkg::S_LOOK : fol_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fol_pkg::S_IDLE;
			end
		endcase
		cmd.load = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == fol_pkg::S_LOOK)
		else $error("accepted beat did not start a search");

	a_look_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fol_pkg::S_LOOK |=> state_q == fol_pkg::S_UPDATE)
		else $error("search not followed by update");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fol_pkg::S_UPDATE && out_valid_q && !out_ready
		|=> state_q == fol_pkg::S_UPDATE && out_valid_q)
		else $error("update committed while the result register was occupied");

endmodule
`default_nettype wire

@@ rtl/frequency_ordered_lookup_table_unit.sv @@
// Frequency-ordered lookup table: up to ENTRIES signed 32-bit keys kept
// front to back by access count, each with a saturating 16-bit count.
// Input channel (in_valid/in_ready) carries one operation per beat: func
// selects append, locate or clear, and key_value holds the key. Each input
// beat produces exactly one output beat (out_valid/out_ready) with status
// (ok, not found, table full) and the new front-relative position of a
// located entry, modulo 8.
// Each operation passes through a search state, which compares the key
// against every entry in parallel, and then an update state, which shifts
// the passed-over entries back one slot and writes the result register.
// A new beat is accepted when idle, or in the update state of the previous
// one once the output register is free. If the receiver stalls with a
// result still waiting, a beat is still taken while idle but holds in its
// update state, with in_ready low, until the output register drains.
// Reset empties the table and drops out_valid; stored keys are not cleared.
`default_nettype none
module frequency_ordered_lookup_table_unit #(
	parameter int ENTRIES = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           func,
	input  wire logic signed [31:0]   key_value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                status,
	output logic [2:0]                position
);

	// Command bundle from the sequencer to the table datapath.
	fol_pkg::cmd_t cmd;

	// The controller steps each beat through search and update and owns the
	// output valid flag.
	fol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath holds the entries, the comparators, the shift network and
	// the result register.
	fol_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.func      (func),
		.key_value (key_value),
		.status    (status),
		.position  (position)
	);

endmodule
`default_nettype wire
